/* rtl/core/sprite_voxel_face_mesher_assert.svh */
// ----------------------------------------------------------------------------
// Sprite voxel face mesher assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPRITE_VOXEL_FACE_MESHER_ASSERT_SVH
`define SPRITE_VOXEL_FACE_MESHER_ASSERT_SVH

// same-cycle implication
`define SVFM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svfm assertion failed");

// next-cycle implication
`define SVFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svfm assertion failed");

`endif

/* rtl/core/svfm_pkg.sv */
// ----------------------------------------------------------------------------
// svfm_pkg
// Widths, face tables and controller/datapath interface types of the mesher.
// ----------------------------------------------------------------------------
package svfm_pkg;

    localparam int CoordWidth    = 6;
    localparam int SizeWidth     = 7;
    localparam int AlphaWidth    = 8;
    localparam int VertexWidth   = 14;
    localparam int NormalWidth   = 3;
    localparam int ColorWidth    = 12;
    localparam int FaceWidth     = 3;
    localparam int NumFaces      = 6;
    localparam int MaxSide       = 64;
    localparam int CornerSide    = MaxSide + 1;
    localparam int VmapDepth     = CornerSide * CornerSide * 2;
    localparam int VmapAddrWidth = $clog2(VmapDepth);
    localparam int CfgIndexWidth = 1;

    localparam logic [CfgIndexWidth-1:0] CfgImageWidth  = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CfgImageHeight = 1'b1;

    localparam logic [FaceWidth-1:0] FaceFront = 3'd0;
    localparam logic [FaceWidth-1:0] FaceBack  = 3'd1;
    localparam logic [FaceWidth-1:0] FaceLeft  = 3'd2;
    localparam logic [FaceWidth-1:0] FaceRight = 3'd3;
    localparam logic [FaceWidth-1:0] FaceBelow = 3'd4;
    localparam logic [FaceWidth-1:0] FaceAbove = 3'd5;

    localparam logic [SizeWidth-1:0] SizeReset = SizeWidth'(MaxSide);

    // corner offsets {dx, dy, back}, in lookup order tl, tr, bl, br
    localparam logic [2:0] FaceCorner [NumFaces][4] = '{
        '{3'b000, 3'b100, 3'b010, 3'b110},
        '{3'b001, 3'b101, 3'b011, 3'b111},
        '{3'b001, 3'b000, 3'b011, 3'b010},
        '{3'b101, 3'b100, 3'b111, 3'b110},
        '{3'b010, 3'b110, 3'b011, 3'b111},
        '{3'b001, 3'b101, 3'b000, 3'b100}
    };

    // triangle winding pattern per face, bit f for face f
    localparam logic [NumFaces-1:0] FacePattern = 6'b001010;

    localparam logic [1:0] TriOrder [2][2][3] = '{
        '{'{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd2, 2'd3}},
        '{'{2'd1, 2'd3, 2'd0}, '{2'd0, 2'd3, 2'd2}}
    };

    typedef struct packed {
        logic                 clear;
        logic                 load;
        logic                 rd_en;
        logic                 emit;
        logic                 tri_sel;
        logic                 last;
        logic [FaceWidth-1:0] face;
        logic [1:0]           corner;
    } cmd_t;

    typedef struct packed {
        logic                clear_done;
        logic                in_opaque;
        logic                out_free;
        logic [NumFaces-1:0] draw;
    } status_t;

endpackage

/* rtl/core/svfm_ctrl.sv */
// ----------------------------------------------------------------------------
// svfm_ctrl
// Sequencer: map clearing, pixel intake, corner lookups and triangle issue.
// ----------------------------------------------------------------------------
module svfm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  svfm_pkg::status_t status,
    output svfm_pkg::cmd_t    cmd
);
    import svfm_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_WAIT,
        S_EMIT0,
        S_EMIT1
    } state_t;

    state_t               state_reg, state_next;
    logic [FaceWidth-1:0] face_reg, face_next;
    logic [1:0]           corner_reg, corner_next;
    logic [FaceWidth-1:0] next_face;
    logic                 has_next;

    always_comb
    begin
        next_face = face_reg;
        has_next  = 1'b0;
        for (int f = NumFaces - 1; f >= 0; f--)
        begin
            if (FaceWidth'(f) > face_reg && status.draw[f])
            begin
                next_face = FaceWidth'(f);
                has_next  = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        face_next   = face_reg;
        corner_next = corner_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.face    = face_reg;
        cmd.corner  = corner_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid && status.in_opaque;
                if (in_valid && status.in_opaque)
                begin
                    state_next  = S_LOOK;
                    face_next   = FaceFront;
                    corner_next = 2'd0;
                end
            end
            S_LOOK:
            begin
                cmd.rd_en   = 1'b1;
                corner_next = corner_reg + 2'd1;
                if (corner_reg == 2'd3)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_EMIT0;
            end
            S_EMIT0:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.tri_sel = 1'b0;
                    state_next  = S_EMIT1;
                end
            end
            S_EMIT1:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.tri_sel = 1'b1;
                    cmd.last    = !has_next;
                    if (has_next)
                    begin
                        face_next   = next_face;
                        corner_next = 2'd0;
                        state_next  = S_LOOK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            face_reg   <= FaceFront;
            corner_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            face_reg   <= face_next;
            corner_reg <= corner_next;
        end
    end

endmodule

/* rtl/core/svfm_dpath.sv */
// ----------------------------------------------------------------------------
// svfm_dpath
// Configuration, neighbour masking, vertex map, normal slots and result word.
// ----------------------------------------------------------------------------
module svfm_dpath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  svfm_pkg::cmd_t                         cmd,
    output svfm_pkg::status_t                      status,
    input  logic                                  cfg_valid,
    input  logic [svfm_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [svfm_pkg::SizeWidth-1:0]         cfg_data,
    input  logic [svfm_pkg::CoordWidth-1:0]        pixel_x,
    input  logic [svfm_pkg::CoordWidth-1:0]        pixel_y,
    input  logic [svfm_pkg::AlphaWidth-1:0]        alpha,
    input  logic                                  left_filled,
    input  logic                                  right_filled,
    input  logic                                  below_filled,
    input  logic                                  above_filled,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [svfm_pkg::VertexWidth-1:0]       first_vertex,
    output logic [svfm_pkg::VertexWidth-1:0]       second_vertex,
    output logic [svfm_pkg::VertexWidth-1:0]       third_vertex,
    output logic [svfm_pkg::NormalWidth-1:0]       normal_index,
    output logic [svfm_pkg::ColorWidth-1:0]        color_index,
    output logic                                  last_triangle
);
    import svfm_pkg::*;

    logic [SizeWidth-1:0]     width_reg, height_reg;
    logic [CoordWidth-1:0]    x_reg, y_reg;
    logic [NumFaces-1:0]      draw_reg, draw_next;
    logic [ColorWidth-1:0]    color_reg, opaque_count_reg;

    logic [VertexWidth:0]     vmap_mem [VmapDepth];
    logic [VmapAddrWidth-1:0] clear_addr_reg;
    logic [VmapAddrWidth-1:0] rd_addr, raddr_reg;
    logic [VertexWidth:0]     rdata_reg;
    logic                     rvalid_reg;
    logic [1:0]               rcorner_reg;
    logic                     fwd_valid_reg;
    logic [VmapAddrWidth-1:0] fwd_addr_reg;
    logic [VertexWidth:0]     fwd_data_reg;
    logic [VertexWidth-1:0]   vcount_reg;
    logic [VertexWidth-1:0]   vid_reg [4];

    logic [VertexWidth:0]     entry;
    logic                     miss;
    logic                     mem_we;
    logic [VmapAddrWidth-1:0] mem_wa;
    logic [VertexWidth:0]     mem_wd;

    logic [2:0]               corner;
    logic [SizeWidth-1:0]     cx, cy;

    logic [NumFaces-1:0]      nvalid_reg;
    logic [NormalWidth-1:0]   nslot_reg [NumFaces];
    logic [NormalWidth-1:0]   ncount_reg;
    logic [NormalWidth-1:0]   nrm_now;
    logic                     pattern;

    logic                     out_valid_reg;
    logic [VertexWidth-1:0]   first_vertex_reg, second_vertex_reg, third_vertex_reg;
    logic [NormalWidth-1:0]   normal_index_reg;
    logic [ColorWidth-1:0]    color_index_reg;
    logic                     last_triangle_reg;

    logic                     left_ok, right_ok, below_ok, above_ok;

    // drop neighbours that fall outside the configured image
    always_comb
    begin
        left_ok  = left_filled && (pixel_x != '0)
                   && (({1'b0, pixel_x} - 7'd1) < width_reg);
        right_ok = right_filled && (({1'b0, pixel_x} + 7'd1) < width_reg);
        below_ok = below_filled && (({1'b0, pixel_y} + 7'd1) < height_reg);
        above_ok = above_filled && (pixel_y != '0)
                   && (({1'b0, pixel_y} - 7'd1) < height_reg);
        draw_next = {!above_ok, !below_ok, !right_ok, !left_ok, 1'b1, 1'b1};
    end

    always_comb
    begin
        corner  = FaceCorner[cmd.face][cmd.corner];
        cx      = {1'b0, x_reg} + SizeWidth'(corner[2]);
        cy      = {1'b0, y_reg} + SizeWidth'(corner[1]);
        rd_addr = VmapAddrWidth'(cx) * VmapAddrWidth'(CornerSide * 2)
                  + VmapAddrWidth'({cy, corner[0]});
    end

    always_comb
    begin
        entry  = (fwd_valid_reg && fwd_addr_reg == raddr_reg) ? fwd_data_reg : rdata_reg;
        miss   = rvalid_reg && !entry[VertexWidth];
        mem_we = cmd.clear || miss;
        mem_wa = cmd.clear ? clear_addr_reg : raddr_reg;
        mem_wd = cmd.clear ? '0 : {1'b1, vcount_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vmap_mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= vmap_mem[rd_addr];
        end
    end

    always_comb
    begin
        nrm_now = nvalid_reg[cmd.face] ? nslot_reg[cmd.face] : ncount_reg;
        pattern = FacePattern[cmd.face];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= SizeReset;
            height_reg       <= SizeReset;
            opaque_count_reg <= '0;
            clear_addr_reg   <= '0;
            rvalid_reg       <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            vcount_reg       <= '0;
            nvalid_reg       <= '0;
            ncount_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CfgImageWidth:  width_reg  <= cfg_data;
                    CfgImageHeight: height_reg <= cfg_data;
                    default:        width_reg  <= width_reg;
                endcase
            end
            if (cmd.load)
            begin
                opaque_count_reg <= opaque_count_reg + 12'd1;
            end
            if (cmd.clear)
            begin
                clear_addr_reg <= clear_addr_reg + 14'd1;
            end
            rvalid_reg    <= cmd.rd_en;
            fwd_valid_reg <= miss;
            if (miss)
            begin
                vcount_reg <= vcount_reg + 14'd1;
            end
            if (cmd.emit && !cmd.tri_sel && !nvalid_reg[cmd.face])
            begin
                nvalid_reg[cmd.face] <= 1'b1;
                ncount_reg           <= ncount_reg + 3'd1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= pixel_x;
            y_reg     <= pixel_y;
            draw_reg  <= draw_next;
            color_reg <= opaque_count_reg;
        end
        raddr_reg   <= rd_addr;
        rcorner_reg <= cmd.corner;
        if (miss)
        begin
            fwd_addr_reg <= raddr_reg;
            fwd_data_reg <= {1'b1, vcount_reg};
        end
        if (rvalid_reg)
        begin
            vid_reg[rcorner_reg] <= miss ? vcount_reg : entry[VertexWidth-1:0];
        end
        if (cmd.emit && !cmd.tri_sel && !nvalid_reg[cmd.face])
        begin
            nslot_reg[cmd.face] <= ncount_reg;
        end
        if (cmd.emit)
        begin
            first_vertex_reg  <= vid_reg[TriOrder[pattern][cmd.tri_sel][0]];
            second_vertex_reg <= vid_reg[TriOrder[pattern][cmd.tri_sel][1]];
            third_vertex_reg  <= vid_reg[TriOrder[pattern][cmd.tri_sel][2]];
            normal_index_reg  <= nrm_now;
            color_index_reg   <= color_reg;
            last_triangle_reg <= cmd.last;
        end
    end

    assign status.clear_done = (clear_addr_reg == VmapAddrWidth'(VmapDepth - 1));
    assign status.in_opaque  = (alpha != '0);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.draw       = draw_reg;

    assign out_valid     = out_valid_reg;
    assign first_vertex  = first_vertex_reg;
    assign second_vertex = second_vertex_reg;
    assign third_vertex  = third_vertex_reg;
    assign normal_index  = normal_index_reg;
    assign color_index   = color_index_reg;
    assign last_triangle = last_triangle_reg;

endmodule

/* rtl/core/sprite_voxel_face_mesher.sv */
// ----------------------------------------------------------------------------
// sprite_voxel_face_mesher
// Turns column-major sprite pixels into culled, deduplicated voxel triangles.
// ----------------------------------------------------------------------------
// After reset the block clears its vertex map, one entry a cycle, with in_ready
// low; configuration writes are taken throughout. A transparent pixel is taken
// and dropped. An opaque pixel that draws F faces (2 to 6) keeps in_ready low
// while, per face, it reads the four corners through the vertex map's single
// read port, resolves the last corner in S_WAIT and issues the two triangle
// words, each held back while the result side stalls. The last triangle word is
// held in the output register while the next pixel is taken.
module sprite_voxel_face_mesher
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [svfm_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [svfm_pkg::SizeWidth-1:0]         cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [svfm_pkg::CoordWidth-1:0]        pixel_x,
    input  logic [svfm_pkg::CoordWidth-1:0]        pixel_y,
    input  logic [svfm_pkg::AlphaWidth-1:0]        alpha,
    input  logic                                  left_filled,
    input  logic                                  right_filled,
    input  logic                                  below_filled,
    input  logic                                  above_filled,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [svfm_pkg::VertexWidth-1:0]       first_vertex,
    output logic [svfm_pkg::VertexWidth-1:0]       second_vertex,
    output logic [svfm_pkg::VertexWidth-1:0]       third_vertex,
    output logic [svfm_pkg::NormalWidth-1:0]       normal_index,
    output logic [svfm_pkg::ColorWidth-1:0]        color_index,
    output logic                                  last_triangle
);
    import svfm_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    tri_distinct;

    assign cfg_ready = 1'b1;

    svfm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    svfm_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .alpha         (alpha),
        .left_filled   (left_filled),
        .right_filled  (right_filled),
        .below_filled  (below_filled),
        .above_filled  (above_filled),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .third_vertex  (third_vertex),
        .normal_index  (normal_index),
        .color_index   (color_index),
        .last_triangle (last_triangle)
    );

    assign tri_distinct = (first_vertex != second_vertex)
                          && (second_vertex != third_vertex)
                          && (first_vertex != third_vertex);

`include "sprite_voxel_face_mesher_assert.svh"

    `SVFM_ASSERT_NOW(a_emit_when_free, cmd.emit, !out_valid || out_ready)
    `SVFM_ASSERT_NOW(a_distinct_vertices, out_valid, tri_distinct)
    `SVFM_ASSERT_NEXT(a_opaque_busy, in_valid && in_ready && alpha != 8'd0, !in_ready)
    `SVFM_ASSERT_NOW(a_no_intake_busy, cmd.rd_en || cmd.clear, !in_ready)

endmodule

/* bench/tb_sprite_voxel_face_mesher.sv */
// ----------------------------------------------------------------------------
// Sprite voxel face mesher testbench
// Drives pixel words and size writes into the mesher with random gaps and
// result-side stalls. A scoreboard class tracks its own vertex map, normal
// slots and opaque count, and checks every triangle word field by field.
// ----------------------------------------------------------------------------
module tb_sprite_voxel_face_mesher;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CORNER_SIDE    = 65;
    localparam int          CORNER_KEYS    = CORNER_SIDE * CORNER_SIDE * 2;
    localparam int          TARGET_ITEMS   = 210;
    localparam int          SETTLE_CYCLES  = 50;
    localparam int          WATCHDOG_LIMIT = 40000;

    // corner offsets {dx, dy, back} per face: tl, tr, bl, br
    localparam bit [2:0] CORNER_OFS [6][4] = '{
        '{3'b000, 3'b100, 3'b010, 3'b110},
        '{3'b001, 3'b101, 3'b011, 3'b111},
        '{3'b001, 3'b000, 3'b011, 3'b010},
        '{3'b101, 3'b100, 3'b111, 3'b110},
        '{3'b010, 3'b110, 3'b011, 3'b111},
        '{3'b001, 3'b101, 3'b000, 3'b100}
    };
    localparam bit [5:0] FACE_WINDING = 6'b001010;
    localparam bit [1:0] TRI_CORNERS [2][2][3] = '{
        '{'{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd2, 2'd3}},
        '{'{2'd1, 2'd3, 2'd0}, '{2'd0, 2'd3, 2'd2}}
    };

    typedef struct packed {
        bit [5:0] x;
        bit [5:0] y;
        bit [7:0] alpha;
        bit       left_filled;
        bit       right_filled;
        bit       below_filled;
        bit       above_filled;
    } pixel_t;

    typedef struct packed {
        logic [13:0] first_vertex;
        logic [13:0] second_vertex;
        logic [13:0] third_vertex;
        logic [2:0]  normal_index;
        logic [11:0] color_index;
        logic        last_triangle;
    } triangle_t;

    class face_mesh_scoreboard;
        int unsigned image_w;
        int unsigned image_h;
        bit          corner_seen [CORNER_KEYS];
        bit [13:0]   corner_id [CORNER_KEYS];
        int unsigned vertex_total;
        bit          normal_seen [6];
        bit [2:0]    normal_id [6];
        int unsigned normal_total;
        bit [11:0]   opaque_total;
        triangle_t   pending_tris [$];
        int unsigned fail_count;

        function new();
            image_w      = 64;
            image_h      = 64;
            vertex_total = 0;
            normal_total = 0;
            opaque_total = '0;
            fail_count   = 0;
            foreach (corner_seen[i]) corner_seen[i] = 1'b0;
            foreach (normal_seen[i]) normal_seen[i] = 1'b0;
        endfunction

        function void set_reg(bit [svfm_pkg::CfgIndexWidth-1:0] idx, bit [6:0] value);
            if (idx == svfm_pkg::CfgImageWidth)
                image_w = value;
            else
                image_h = value;
        endfunction

        function bit [13:0] corner_lookup(int unsigned x, int unsigned y, bit back);
            int unsigned key;
            key = ((x % CORNER_SIDE) * CORNER_SIDE + (y % CORNER_SIDE)) * 2 + back;
            if (!corner_seen[key])
            begin
                corner_seen[key] = 1'b1;
                corner_id[key]   = vertex_total[13:0];
                vertex_total++;
            end
            return corner_id[key];
        endfunction

        function bit [2:0] normal_lookup(int f);
            if (!normal_seen[f])
            begin
                normal_seen[f] = 1'b1;
                normal_id[f]   = normal_total[2:0];
                normal_total++;
            end
            return normal_id[f];
        endfunction

        function void note_pixel(pixel_t p);
            int unsigned xi;
            int unsigned yi;
            bit          lf;
            bit          rf;
            bit          bf;
            bit          af;
            bit [5:0]    draw;
            int          last_face;
            bit [13:0]   vid [4];
            bit [2:0]    ofs;
            bit [2:0]    nrm;
            bit [11:0]   colour;
            bit          pat;
            triangle_t   tr;
            if (p.alpha == 0)
                return;
            xi = p.x;
            yi = p.y;
            lf = p.left_filled  && xi >= 1 && (xi - 1) < image_w;
            rf = p.right_filled && (xi + 1) < image_w;
            bf = p.below_filled && (yi + 1) < image_h;
            af = p.above_filled && yi >= 1 && (yi - 1) < image_h;
            draw = 6'b111111;
            draw[svfm_pkg::FaceLeft]  = !lf;
            draw[svfm_pkg::FaceRight] = !rf;
            draw[svfm_pkg::FaceBelow] = !bf;
            draw[svfm_pkg::FaceAbove] = !af;
            last_face = 0;
            for (int f = 0; f < 6; f++)
                if (draw[f])
                    last_face = f;
            colour = opaque_total;
            opaque_total++;
            for (int f = 0; f < 6; f++)
            begin
                if (!draw[f])
                    continue;
                for (int k = 0; k < 4; k++)
                begin
                    ofs    = CORNER_OFS[f][k];
                    vid[k] = corner_lookup(xi + ofs[2], yi + ofs[1], ofs[0]);
                end
                nrm = normal_lookup(f);
                pat = FACE_WINDING[f];
                for (int t = 0; t < 2; t++)
                begin
                    tr.first_vertex  = vid[TRI_CORNERS[pat][t][0]];
                    tr.second_vertex = vid[TRI_CORNERS[pat][t][1]];
                    tr.third_vertex  = vid[TRI_CORNERS[pat][t][2]];
                    tr.normal_index  = nrm;
                    tr.color_index   = colour;
                    tr.last_triangle = (f == last_face) && (t == 1);
                    pending_tris = {pending_tris, tr};
                end
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_triangle(triangle_t got);
            triangle_t want;
            if (pending_tris.size() == 0)
            begin
                $error("triangle word with none pending: %p", got);
                fail_count++;
                return;
            end
            want = pending_tris.pop_front();
            compare_field("first_vertex", want.first_vertex, got.first_vertex);
            compare_field("second_vertex", want.second_vertex, got.second_vertex);
            compare_field("third_vertex", want.third_vertex, got.third_vertex);
            compare_field("normal_index", want.normal_index, got.normal_index);
            compare_field("color_index", want.color_index, got.color_index);
            compare_field("last_triangle", want.last_triangle, got.last_triangle);
        endfunction

        function int unsigned pending_count();
            return pending_tris.size();
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [svfm_pkg::CfgIndexWidth-1:0]   cfg_index;
    logic [svfm_pkg::SizeWidth-1:0]       cfg_data;
    logic                                 in_valid;
    logic                                 in_ready;
    logic [svfm_pkg::CoordWidth-1:0]      pixel_x;
    logic [svfm_pkg::CoordWidth-1:0]      pixel_y;
    logic [svfm_pkg::AlphaWidth-1:0]      alpha;
    logic                                 left_filled;
    logic                                 right_filled;
    logic                                 below_filled;
    logic                                 above_filled;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [svfm_pkg::VertexWidth-1:0]     first_vertex;
    logic [svfm_pkg::VertexWidth-1:0]     second_vertex;
    logic [svfm_pkg::VertexWidth-1:0]     third_vertex;
    logic [svfm_pkg::NormalWidth-1:0]     normal_index;
    logic [svfm_pkg::ColorWidth-1:0]      color_index;
    logic                                 last_triangle;

    face_mesh_scoreboard board;
    bit                  no_gaps;
    int unsigned         items_sent;
    int unsigned         stall_left;
    int unsigned         idle_cycles;

    sprite_voxel_face_mesher u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .alpha         (alpha),
        .left_filled   (left_filled),
        .right_filled  (right_filled),
        .below_filled  (below_filled),
        .above_filled  (above_filled),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .third_vertex  (third_vertex),
        .normal_index  (normal_index),
        .color_index   (color_index),
        .last_triangle (last_triangle)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // nbr is {left, right, below, above}
    task automatic send_pixel(input bit [5:0] x, input bit [5:0] y, input bit [7:0] a,
                              input bit [3:0] nbr);
        int unsigned gap;
        pixel_t      p;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        pixel_x      <= x;
        pixel_y      <= y;
        alpha        <= a;
        left_filled  <= nbr[3];
        right_filled <= nbr[2];
        below_filled <= nbr[1];
        above_filled <= nbr[0];
        p = '{x, y, a, nbr[3], nbr[2], nbr[1], nbr[0]};
        do @(posedge clk); while (!in_ready);
        board.note_pixel(p);
        items_sent++;
    endtask

    task automatic write_reg(input bit [svfm_pkg::CfgIndexWidth-1:0] idx, input bit [6:0] value);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, value);
    endtask

    task automatic set_sizes(input bit [6:0] w, input bit [6:0] h);
        write_reg(svfm_pkg::CfgImageWidth, w);
        write_reg(svfm_pkg::CfgImageHeight, h);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, wait for every pending triangle, then let the pipe go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // column-major sprite with flags consistent inside it, random at its rim
    task automatic send_sprite(input int ox, input int oy, input int w, input int h);
        bit       solid [8][8];
        bit [3:0] nbr;
        for (int c = 0; c < w; c++)
            for (int r = 0; r < h; r++)
                solid[c][r] = ($urandom_range(0, 3) != 0);
        for (int c = 0; c < w; c++)
            for (int r = 0; r < h; r++)
            begin
                nbr[3] = (c > 0)     ? solid[c-1][r] : 1'($urandom_range(0, 1));
                nbr[2] = (c < w - 1) ? solid[c+1][r] : 1'($urandom_range(0, 1));
                nbr[1] = (r < h - 1) ? solid[c][r+1] : 1'($urandom_range(0, 1));
                nbr[0] = (r > 0)     ? solid[c][r-1] : 1'($urandom_range(0, 1));
                send_pixel(6'(ox + c), 6'(oy + r),
                           solid[c][r] ? 8'($urandom_range(1, 255)) : 8'd0, nbr);
            end
    endtask

    function automatic bit [6:0] pick_size();
        case ($urandom_range(0, 4))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    always @(posedge clk)
    begin : result_sink
        triangle_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{first_vertex, second_vertex, third_vertex,
                    normal_index, color_index, last_triangle};
            board.check_triangle(got);
            stall_left = no_gaps ? 0 : $urandom_range(0, 19);
            if (stall_left != 0)
                out_ready <= 1'b0;
        end
        else if (!out_ready)
        begin
            if (stall_left > 0)
                stall_left--;
            if (stall_left == 0)
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int w;
        int h;
        int ox;
        int oy;
        int noise;
        board        = new();
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pixel_x      = '0;
        pixel_y      = '0;
        alpha        = '0;
        left_filled  = 1'b0;
        right_filled = 1'b0;
        below_filled = 1'b0;
        above_filled = 1'b0;
        out_ready    = 1'b1;
        no_gaps      = 1'b0;
        items_sent   = 0;
        stall_left   = 0;
        idle_cycles  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: corner masking, transparent drop, vertex sharing
        send_pixel(6'd0, 6'd0, 8'd255, 4'b1111);
        send_pixel(6'd63, 6'd63, 8'd1, 4'b1111);
        send_pixel(6'd63, 6'd0, 8'd128, 4'b0000);
        send_pixel(6'd10, 6'd10, 8'd0, 4'b1111);
        send_pixel(6'd1, 6'd0, 8'h55, 4'b1111);
        send_pixel(6'd20, 6'd20, 8'hAA, 4'b1111);
        send_pixel(6'd0, 6'd63, 8'h0F, 4'b1010);
        send_pixel(6'd1, 6'd1, 8'hF0, 4'b0101);
        settle();

        // zero sizes mask every neighbour
        set_sizes(7'd0, 7'd0);
        send_pixel(6'd5, 6'd5, 8'd77, 4'b1111);
        send_pixel(6'd0, 6'd0, 8'd0, 4'b1111);
        send_pixel(6'd0, 6'd1, 8'd200, 4'b1111);
        settle();

        // sizes above the side
        set_sizes(7'd127, 7'd127);
        send_pixel(6'd62, 6'd62, 8'd9, 4'b1111);
        send_pixel(6'd63, 6'd63, 8'd10, 4'b1111);
        send_pixel(6'd63, 6'd62, 8'd0, 4'b0000);
        settle();

        // one-pixel image, pixels outside it
        set_sizes(7'd1, 7'd1);
        send_pixel(6'd0, 6'd0, 8'd3, 4'b1111);
        send_pixel(6'd3, 6'd3, 8'd4, 4'b1111);
        send_pixel(6'd1, 6'd0, 8'd5, 4'b1111);
        send_pixel(6'd40, 6'd2, 8'd6, 4'b0110);
        settle();

        while (items_sent < TARGET_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            if ($urandom_range(0, 1))
            begin
                ox = 0;
                oy = 0;
                set_sizes(7'(w), 7'(h));
            end
            else
            begin
                ox = $urandom_range(0, 64 - w);
                oy = $urandom_range(0, 64 - h);
                set_sizes(pick_size(), pick_size());
            end
            send_sprite(ox, oy, w, h);
            noise = $urandom_range(0, 4);
            repeat (noise)
                send_pixel(6'($urandom), 6'($urandom),
                           ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                           4'($urandom));
            settle();
        end

        if (board.fail_count == 0 && board.pending_count() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
